/* rtl/core/qalu_pkg.sv */
// shared types, constants and helpers of the quaternion arithmetic unit
package qalu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 4;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_QBITS     = 33;
    localparam int DIV_LAT       = DIV_QBITS + 1;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_DIV       = 4'd3,
        OP_PROD_REAL = 4'd4,
        OP_CONJ      = 4'd5,
        OP_INV       = 4'd6,
        OP_NORMALIZE = 4'd7,
        OP_NORM      = 4'd8,
        OP_NORM_SQ   = 4'd9
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic signed [31:0] t_fix;
    typedef logic signed [63:0] t_wide;

    localparam t_fix MAX32 = 32'sh7fffffff;
    localparam t_fix MIN32 = 32'sh80000000;

    // lane k sums a[i]*b[i^k]; bit i set means that term is subtracted
    localparam logic [3:0] MUL_NEG [LANES] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};
    localparam logic [3:0] DIV_NEG [LANES] = '{4'b0000, 4'b0101, 4'b1001, 4'b0011};

    typedef struct packed {
        logic [3:0] operation;
        t_fix       a_w;
        t_fix       a_i;
        t_fix       a_j;
        t_fix       a_k;
        t_fix       b_w;
        t_fix       b_i;
        t_fix       b_j;
        t_fix       b_k;
    } t_in_beat;

    typedef struct packed {
        t_fix       r_w;
        t_fix       r_i;
        t_fix       r_j;
        t_fix       r_k;
        logic [1:0] status;
    } t_out_beat;

    typedef struct packed {
        t_fix value;
        logic sat;
    } t_sat;

    function automatic t_sat sat32(input t_wide v);
        t_sat s;
        s.sat = 1'b1;
        if (v > t_wide'(MAX32)) begin
            s.value = MAX32;
        end else if (v < t_wide'(MIN32)) begin
            s.value = MIN32;
        end else begin
            s.sat   = 1'b0;
            s.value = v[31:0];
        end
        return s;
    endfunction

endpackage

/* rtl/core/qalu_if.sv */
// valid/ready channel interface carrying one beat of payload
interface qalu_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/qalu_mul_lane.sv */
// one product lane: four signed products, floor shift and signed sum, plus two squares
module qalu_mul_lane #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF,
    parameter int LANE      = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_div,
    input  qalu_pkg::t_fix   i_a [qalu_pkg::LANES],
    input  qalu_pkg::t_fix   i_b [qalu_pkg::LANES],
    output qalu_pkg::t_wide  o_p,
    output qalu_pkg::t_wide  o_sq_a,
    output qalu_pkg::t_wide  o_sq_b
);
    localparam logic [1:0] LANE_IDX = LANE[1:0];

    qalu_pkg::t_wide r_prod [qalu_pkg::LANES];
    qalu_pkg::t_wide r_sqa;
    qalu_pkg::t_wide r_sqb;
    logic            r_div;
    qalu_pkg::t_wide r_p;
    qalu_pkg::t_wide r_fa;
    qalu_pkg::t_wide r_fb;
    qalu_pkg::t_wide n_p;

    for (genvar i = 0; i < qalu_pkg::LANES; i++) begin : g_prod
        localparam logic [1:0] BI = 2'(i) ^ LANE_IDX;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[i] <= i_a[i] * i_b[BI];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqa <= i_a[LANE_IDX] * i_a[LANE_IDX];
            r_sqb <= i_b[LANE_IDX] * i_b[LANE_IDX];
            r_div <= i_div;
        end
    end

    // floored terms, sign pattern depends on product or conjugate product
    always_comb begin
        logic [3:0]      neg;
        qalu_pkg::t_wide term;
        neg = r_div ? qalu_pkg::DIV_NEG[LANE_IDX] : qalu_pkg::MUL_NEG[LANE_IDX];
        n_p = '0;
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
            term = r_prod[i] >>> FRAC_BITS;
            n_p  = neg[i] ? (n_p - term) : (n_p + term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_fa <= r_sqa >>> FRAC_BITS;
            r_fb <= r_sqb >>> FRAC_BITS;
        end
    end

    assign o_p    = r_p;
    assign o_sq_a = r_fa;
    assign o_sq_b = r_fb;
endmodule

/* rtl/core/qalu_sqrt.sv */
// pipelined integer square root, one result bit per stage
module qalu_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    localparam int NS = qalu_pkg::SQRT_STAGES;

    logic [63:0] r_x   [NS-1];
    logic [63:0] r_res [NS];

    for (genvar t = 0; t < NS; t++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (NS - 1 - t));
        logic [63:0] w_x;
        logic [63:0] w_r;
        logic [63:0] w_sum;
        logic        w_ge;

        if (t == 0) begin : g_first
            assign w_x = i_val;
            assign w_r = '0;
        end else begin : g_next
            assign w_x = r_x[t-1];
            assign w_r = r_res[t-1];
        end

        assign w_sum = w_r + BIT;
        assign w_ge  = w_x >= w_sum;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[t] <= w_ge ? ((w_r >> 1) + BIT) : (w_r >> 1);
            end
        end

        if (t < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[t] <= w_ge ? (w_x - w_sum) : w_x;
                end
            end
        end
    end

    assign o_root = r_res[NS-1][31:0];
endmodule

/* rtl/core/qalu_div_lane.sv */
// pipelined restoring divider: num * 2^frac / den, truncated, clamped to 32 bits
module qalu_div_lane #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  qalu_pkg::t_wide i_num,
    input  logic [63:0]     i_den,
    output qalu_pkg::t_fix  o_q,
    output logic            o_sat
);
    localparam int DW = 64 + FRAC_BITS;
    localparam int QB = qalu_pkg::DIV_QBITS;

    logic [64:0]   r_rem [QB];
    logic [QB-1:0] r_low [QB];
    logic [63:0]   r_den [QB];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];

    logic          w_neg;
    logic [63:0]   w_mag;
    logic [DW-1:0] w_dvd;
    logic [64:0]   w_top;

    assign w_neg = i_num[63];
    assign w_mag = w_neg ? (~i_num + 64'd1) : i_num;
    assign w_dvd = {w_mag, {FRAC_BITS{1'b0}}};
    assign w_top = 65'(w_dvd[DW-1:QB]);

    // high part already at or above den means quotient of 2^33 or more
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_top;
            r_low[0] <= w_dvd[QB-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= w_neg;
            r_ovf[0] <= w_top >= {1'b0, i_den};
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [64:0] w_sh;
        logic        w_ge;

        assign w_sh = {r_rem[j-1][63:0], r_low[j-1][QB-1]};
        assign w_ge = w_sh >= {1'b0, r_den[j-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]   <= {r_q[j-1][QB-2:0], w_ge};
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end

        if (j < QB) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? (w_sh - {1'b0, r_den[j-1]}) : w_sh;
                    r_low[j] <= {r_low[j-1][QB-2:0], 1'b0};
                    r_den[j] <= r_den[j-1];
                end
            end
        end
    end

    // sign and clamp
    always_comb begin
        logic [31:0] m;
        m     = r_q[QB][QB-2:0];
        o_sat = 1'b0;
        if (r_ovf[QB] || r_q[QB][QB-1]) begin
            o_sat = 1'b1;
            o_q   = r_neg[QB] ? qalu_pkg::MIN32 : qalu_pkg::MAX32;
        end else if (r_neg[QB]) begin
            if (m > 32'h8000_0000) begin
                o_sat = 1'b1;
                o_q   = qalu_pkg::MIN32;
            end else begin
                o_q   = ~m + 32'd1;
            end
        end else if (m[31]) begin
            o_sat = 1'b1;
            o_q   = qalu_pkg::MAX32;
        end else begin
            o_q   = m;
        end
    end
endmodule

/* rtl/core/quaternion_alu_core.sv */
// quaternion arithmetic unit top level: four component lanes, norm root, four dividers
// throughput: one beat per cycle, sustained while the sink takes results
// depth is set by the 32-stage square root feeding the 34-stage divider lanes
// all operations run the same pipeline, so results leave in input order
// reset (synchronous, active low) clears the valid bits; data registers are not reset
module quaternion_alu_core #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    qalu_if.sink   i_in,
    qalu_if.source o_out
);
    localparam int NL = qalu_pkg::LANES;
    localparam int NS = qalu_pkg::SQRT_STAGES;
    localparam int ND = qalu_pkg::DIV_LAT;

    // sideband carried alongside the square root
    typedef struct packed {
        qalu_pkg::t_op                    op;
        qalu_pkg::t_fix  [NL-1:0]         s;
        logic            [NL-1:0]         ss;
        qalu_pkg::t_wide [NL-1:0]         num;
        logic            [63:0]           det;
        logic                             sqov;
    } t_side_a;

    // sideband carried alongside the dividers
    typedef struct packed {
        qalu_pkg::t_op                    op;
        logic                             zero;
        qalu_pkg::t_fix  [NL-1:0]         s;
        logic            [NL-1:0]         ss;
    } t_side_b;

    function automatic logic is_divlike(input qalu_pkg::t_op op);
        return (op == qalu_pkg::OP_DIV) || (op == qalu_pkg::OP_INV) ||
               (op == qalu_pkg::OP_NORMALIZE);
    endfunction

    // pipeline advances whenever the output register is free or being drained
    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage 0: input register ----------------
    logic            r_v0;
    qalu_pkg::t_op   r_op0;
    qalu_pkg::t_fix  r_a0 [NL];
    qalu_pkg::t_fix  r_b0 [NL];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op0   <= qalu_pkg::t_op'(i_in.data.operation);
            r_a0[0] <= i_in.data.a_w;
            r_a0[1] <= i_in.data.a_i;
            r_a0[2] <= i_in.data.a_j;
            r_a0[3] <= i_in.data.a_k;
            r_b0[0] <= i_in.data.b_w;
            r_b0[1] <= i_in.data.b_i;
            r_b0[2] <= i_in.data.b_j;
            r_b0[3] <= i_in.data.b_k;
        end
    end

    // ---------------- stages 1-2: product lanes, simple ops ----------------
    qalu_pkg::t_wide w_p   [NL];
    qalu_pkg::t_wide w_sqa [NL];
    qalu_pkg::t_wide w_sqb [NL];

    for (genvar k = 0; k < NL; k++) begin : g_lane
        qalu_mul_lane #(
            .FRAC_BITS (FRAC_BITS),
            .LANE      (k)
        ) u_mul (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_div  (r_op0 == qalu_pkg::OP_DIV),
            .i_a    (r_a0),
            .i_b    (r_b0),
            .o_p    (w_p[k]),
            .o_sq_a (w_sqa[k]),
            .o_sq_b (w_sqb[k])
        );
    end

    // add, sub and conjugate need no products
    qalu_pkg::t_fix n_s1  [NL];
    logic           n_ss1 [NL];

    always_comb begin
        qalu_pkg::t_sat t;
        for (int k = 0; k < NL; k++) begin
            case (r_op0)
                qalu_pkg::OP_ADD: begin
                    t = qalu_pkg::sat32(qalu_pkg::t_wide'(r_a0[k]) +
                                        qalu_pkg::t_wide'(r_b0[k]));
                end
                qalu_pkg::OP_SUB: begin
                    t = qalu_pkg::sat32(qalu_pkg::t_wide'(r_a0[k]) -
                                        qalu_pkg::t_wide'(r_b0[k]));
                end
                qalu_pkg::OP_CONJ: begin
                    if (k == 0) begin
                        t.value = r_a0[k];
                        t.sat   = 1'b0;
                    end else begin
                        t = qalu_pkg::sat32(-qalu_pkg::t_wide'(r_a0[k]));
                    end
                end
                default: begin
                    t = '0;
                end
            endcase
            n_s1[k]  = t.value;
            n_ss1[k] = t.sat;
        end
    end

    logic            r_v1, r_v2;
    qalu_pkg::t_op   r_op1, r_op2;
    qalu_pkg::t_fix  r_a1 [NL];
    qalu_pkg::t_fix  r_a2 [NL];
    qalu_pkg::t_fix  r_s1 [NL];
    qalu_pkg::t_fix  r_s2 [NL];
    logic            r_ss1 [NL];
    logic            r_ss2 [NL];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1 <= r_op0;
            r_a1  <= r_a0;
            r_s1  <= n_s1;
            r_ss1 <= n_ss1;
            r_op2 <= r_op1;
            r_a2  <= r_a1;
            r_s2  <= r_s1;
            r_ss2 <= r_ss1;
        end
    end

    // ---------------- stage 3: merge lanes, squared norms ----------------
    logic [63:0] w_det_a;
    logic [63:0] w_det_b;
    t_side_a     n_side3;
    logic [63:0] n_sqin3;

    always_comb begin
        qalu_pkg::t_sat t;
        w_det_a = '0;
        w_det_b = '0;
        for (int k = 0; k < NL; k++) begin
            w_det_a = w_det_a + w_sqa[k];
            w_det_b = w_det_b + w_sqb[k];
        end

        n_side3.op   = r_op2;
        n_side3.s    = '0;
        n_side3.ss   = '0;
        n_side3.det  = (r_op2 == qalu_pkg::OP_DIV) ? w_det_b : w_det_a;
        n_side3.sqov = (w_det_a >> (64 - FRAC_BITS)) != 64'd0;
        n_sqin3      = w_det_a << FRAC_BITS;

        for (int k = 0; k < NL; k++) begin
            case (r_op2)
                qalu_pkg::OP_DIV:       n_side3.num[k] = w_p[k];
                qalu_pkg::OP_INV: begin
                    n_side3.num[k] = (k == 0) ? qalu_pkg::t_wide'(r_a2[k])
                                              : -qalu_pkg::t_wide'(r_a2[k]);
                end
                default:                n_side3.num[k] = qalu_pkg::t_wide'(r_a2[k]);
            endcase
        end

        for (int k = 0; k < NL; k++) begin
            case (r_op2)
                qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_CONJ: begin
                    n_side3.s[k]  = r_s2[k];
                    n_side3.ss[k] = r_ss2[k];
                end
                qalu_pkg::OP_MUL: begin
                    t = qalu_pkg::sat32(w_p[k]);
                    n_side3.s[k]  = t.value;
                    n_side3.ss[k] = t.sat;
                end
                qalu_pkg::OP_PROD_REAL: begin
                    if (k == 0) begin
                        t = qalu_pkg::sat32(w_p[k]);
                        n_side3.s[k]  = t.value;
                        n_side3.ss[k] = t.sat;
                    end
                end
                qalu_pkg::OP_NORM_SQ: begin
                    if (k == 0) begin
                        t = qalu_pkg::sat32(w_det_a);
                        n_side3.s[k]  = t.value;
                        n_side3.ss[k] = t.sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    logic        r_v3;
    t_side_a     r_side3;
    logic [63:0] r_sqin3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side3 <= n_side3;
            r_sqin3 <= n_sqin3;
        end
    end

    // ---------------- stages 4-35: norm square root ----------------
    logic [31:0] w_root;

    qalu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_sqin3),
        .o_root (w_root)
    );

    t_side_a        r_da  [NS];
    logic [NS-1:0]  r_dav;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_da[0] <= r_side3;
            for (int s = 1; s < NS; s++) begin
                r_da[s] <= r_da[s-1];
            end
        end
    end

    // ---------------- stage 36: divisor select, zero check ----------------
    logic [32:0]     w_norm;
    logic [63:0]     n_den36;
    t_side_b         n_side36;

    always_comb begin
        w_norm         = r_da[NS-1].sqov ? {1'b1, 32'd0} : {1'b0, w_root};
        n_side36.op    = r_da[NS-1].op;
        n_side36.s     = r_da[NS-1].s;
        n_side36.ss    = r_da[NS-1].ss;
        if (r_da[NS-1].op == qalu_pkg::OP_NORM) begin
            if (w_norm[32] || w_norm[31]) begin
                n_side36.s[0]  = qalu_pkg::MAX32;
                n_side36.ss[0] = 1'b1;
            end else begin
                n_side36.s[0]  = w_norm[31:0];
                n_side36.ss[0] = 1'b0;
            end
        end
        n_den36 = (r_da[NS-1].op == qalu_pkg::OP_NORMALIZE) ? 64'(w_norm)
                                                           : r_da[NS-1].det;
        n_side36.zero = is_divlike(r_da[NS-1].op) && (n_den36 == 64'd0);
    end

    logic            r_v36;
    t_side_b         r_side36;
    qalu_pkg::t_wide r_num36 [NL];
    logic [63:0]     r_den36;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side36 <= n_side36;
            r_den36  <= n_den36;
            for (int k = 0; k < NL; k++) begin
                r_num36[k] <= r_da[NS-1].num[k];
            end
        end
    end

    // ---------------- stages 37-70: divider lanes ----------------
    qalu_pkg::t_fix w_q   [NL];
    logic           w_qs  [NL];

    for (genvar k = 0; k < NL; k++) begin : g_div
        qalu_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num36[k]),
            .i_den (r_den36),
            .o_q   (w_q[k]),
            .o_sat (w_qs[k])
        );
    end

    t_side_b        r_db  [ND];
    logic [ND-1:0]  r_dbv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_db[0] <= r_side36;
            for (int s = 1; s < ND; s++) begin
                r_db[s] <= r_db[s-1];
            end
        end
    end

    // ---------------- output stage: pick results, merge status ----------------
    qalu_pkg::t_fix      w_res [NL];
    logic                w_any_sat;
    qalu_pkg::t_out_beat n_out;
    qalu_pkg::t_out_beat r_out;

    always_comb begin
        w_any_sat = 1'b0;
        for (int k = 0; k < NL; k++) begin
            if (is_divlike(r_db[ND-1].op)) begin
                w_res[k]  = r_db[ND-1].zero ? '0 : w_q[k];
                w_any_sat = w_any_sat | (!r_db[ND-1].zero && w_qs[k]);
            end else begin
                w_res[k]  = r_db[ND-1].s[k];
                w_any_sat = w_any_sat | r_db[ND-1].ss[k];
            end
        end
        n_out.r_w    = w_res[0];
        n_out.r_i    = w_res[1];
        n_out.r_j    = w_res[2];
        n_out.r_k    = w_res[3];
        n_out.status = r_db[ND-1].zero ? qalu_pkg::ST_ZERO :
                       (w_any_sat ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    // valid bits, one per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_dav       <= '0;
            r_v36       <= 1'b0;
            r_dbv       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v0        <= i_in.valid;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_dav       <= {r_dav[NS-2:0], r_v3};
            r_v36       <= r_dav[NS-1];
            r_dbv       <= {r_dbv[ND-2:0], r_v36};
            r_out_valid <= r_dbv[ND-1];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // a result beat that is not taken stays
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("result beat dropped while stalled");

    // zero divisor status comes with an all-zero quaternion
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == qalu_pkg::ST_ZERO) |->
        (r_out.r_w == '0) && (r_out.r_i == '0) && (r_out.r_j == '0) && (r_out.r_k == '0))
        else $error("zero status with nonzero result");

    // zero flag only ever raised for the dividing operations
    a_zero_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v36 && r_side36.zero |->
        (r_side36.op == qalu_pkg::OP_DIV) || (r_side36.op == qalu_pkg::OP_INV) ||
        (r_side36.op == qalu_pkg::OP_NORMALIZE))
        else $error("zero flag on non-dividing operation");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status != 2'd3))
        else $error("illegal status code");
endmodule
